// ----- rtl/core/ncc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_pkg: shared constants for the nearest centroid classifier
// Sizes, register map helpers and centroid reset coordinates.
// ----------------------------------------------------------------------------
package ncc_pkg;

  localparam int NUM_CENTROIDS = 4;   // 1..4 centroids take part
  localparam int COORD_BITS    = 8;   // coordinate bits that are used

  localparam int SLOTS    = 4;        // centroid register slots
  localparam int IDX_W    = 2;        // centroid index width
  localparam int PORT_W   = 8;        // coordinate port width
  localparam int CW       = (COORD_BITS < PORT_W) ? COORD_BITS : PORT_W;
  localparam int SQ_W     = 2 * CW;   // one squared difference
  localparam int DW       = SQ_W + 1; // sum of two squares
  localparam int DIST_W   = 17;       // output distance field
  localparam int CNT_W    = 32;
  localparam int ADDR_W   = 5;        // byte address, 8 registers at 4*i
  localparam int DATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // axis select bit of a register index
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  localparam logic [PORT_W-1:0] RESET_COORD [SLOTS][2] = '{
    '{8'd75, 8'd25},
    '{8'd25, 8'd25},
    '{8'd25, 8'd75},
    '{8'd75, 8'd75}
  };

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  // fit a distance sum into the output field (zero extend or truncate)
  function automatic logic [DIST_W-1:0] fit_dist(input logic [DW-1:0] d);
    logic [DW+DIST_W-1:0] tmp;
    tmp = (DW + DIST_W)'(d);
    return tmp[DIST_W-1:0];
  endfunction

endpackage

// ----- rtl/core/nearest_centroid_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_classifier: k-means assignment step
// Classifies 2D points against four centroids and counts assignments.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one point per transaction.
//   Output channel (out_valid / out_stall) returns one result per point:
//   nearest centroid index (lowest index on ties), squared distance,
//   that centroid's updated count and the running point total. Both
//   counters saturate at 2^32-1.
//   Centroid coordinates sit in eight APB registers at byte address 4*i
//   (x0, y0, x1, y1, ...); write them only while the block is idle.
// Timing:
//   Three-stage pipeline: squares, min search plus counter read, counter
//   update into the output register. One point is accepted every cycle
//   unless a held result is stalled.
//   The per-centroid counters live in a 4-entry memory with a registered
//   read; a back-to-back hit on the same entry takes the last written
//   value through a forwarding register.
// Reset:
//   rst_n (sync, active low) empties the pipeline, restores default
//   centroids, zeroes the total and marks all counter entries as zero.
// Backpressure: out_stall on a held result freezes the whole pipeline and
//   raises in_stall in the same cycle; the held result stays stable.
// ----------------------------------------------------------------------------
module nearest_centroid_classifier (
  input  logic                        clk,
  input  logic                        rst_n,
  // point input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ncc_pkg::PORT_W-1:0]  in_point_x,
  input  logic [ncc_pkg::PORT_W-1:0]  in_point_y,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ncc_pkg::IDX_W-1:0]   out_nearest_index,
  output logic [ncc_pkg::DIST_W-1:0]  out_nearest_sq_distance,
  output logic [ncc_pkg::CNT_W-1:0]   out_nearest_count,
  output logic [ncc_pkg::CNT_W-1:0]   out_points_seen,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ncc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ncc_pkg::DATA_W-1:0]  pwdata,
  output logic [ncc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int NC = ncc_pkg::NUM_CENTROIDS;
  localparam int CW = ncc_pkg::CW;

  // --------------------------------------------------------------------------
  // Centroid registers
  // --------------------------------------------------------------------------
  logic [ncc_pkg::PORT_W-1:0]    centroid_r [ncc_pkg::SLOTS][2];
  logic [ncc_pkg::REG_IDX_W-1:0] reg_idx;
  logic [ncc_pkg::IDX_W-1:0]     reg_slot;
  logic                          reg_axis;
  logic                          cfg_wr;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[ncc_pkg::ADDR_W-1:2];
  assign reg_slot = reg_idx[ncc_pkg::REG_IDX_W-1:1];
  assign reg_axis = reg_idx[0];
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = ncc_pkg::DATA_W'(centroid_r[reg_slot][reg_axis]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ncc_pkg::SLOTS; s++) begin
        centroid_r[s][ncc_pkg::AXIS_X] <= ncc_pkg::RESET_COORD[s][0];
        centroid_r[s][ncc_pkg::AXIS_Y] <= ncc_pkg::RESET_COORD[s][1];
      end
    end else if (cfg_wr) begin
      centroid_r[reg_slot][reg_axis] <= pwdata[ncc_pkg::PORT_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: the whole pipe moves unless a held result is stalled
  // --------------------------------------------------------------------------
  logic advance;
  logic s1_v_r, s2_v_r, out_v_r;

  assign advance  = !out_v_r || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r  <= in_valid;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: per-centroid absolute differences and squares
  // --------------------------------------------------------------------------
  logic [ncc_pkg::SQ_W-1:0] s1_sqx_r [NC];
  logic [ncc_pkg::SQ_W-1:0] s1_sqy_r [NC];
  logic [CW-1:0]            px, py;

  assign px = in_point_x[CW-1:0];
  assign py = in_point_y[CW-1:0];

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int j = 0; j < NC; j++) begin
        logic [CW-1:0] cx, cy, dx, dy;
        cx = centroid_r[j][ncc_pkg::AXIS_X][CW-1:0];
        cy = centroid_r[j][ncc_pkg::AXIS_Y][CW-1:0];
        dx = (px >= cx) ? px - cx : cx - px;
        dy = (py >= cy) ? py - cy : cy - py;
        s1_sqx_r[j] <= ncc_pkg::SQ_W'(dx) * ncc_pkg::SQ_W'(dx);
        s1_sqy_r[j] <= ncc_pkg::SQ_W'(dy) * ncc_pkg::SQ_W'(dy);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sums, strict less-than min search, counter memory read
  // --------------------------------------------------------------------------
  logic [ncc_pkg::DW-1:0]    best_dist;
  logic [ncc_pkg::IDX_W-1:0] best_idx;

  always_comb begin
    logic [ncc_pkg::DW-1:0] d;
    best_dist = ncc_pkg::DW'(s1_sqx_r[0]) + ncc_pkg::DW'(s1_sqy_r[0]);
    best_idx  = '0;
    for (int j = 1; j < NC; j++) begin
      d = ncc_pkg::DW'(s1_sqx_r[j]) + ncc_pkg::DW'(s1_sqy_r[j]);
      if (d < best_dist) begin
        best_dist = d;
        best_idx  = ncc_pkg::IDX_W'(j);
      end
    end
  end

  logic [ncc_pkg::IDX_W-1:0] s2_idx_r;
  logic [ncc_pkg::DW-1:0]    s2_dist_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_idx_r  <= best_idx;
      s2_dist_r <= best_dist;
    end
  end

  // counter memory, one write and one registered read per cycle while the pipe advances
  logic [ncc_pkg::CNT_W-1:0] cnt_mem [ncc_pkg::SLOTS];
  logic [ncc_pkg::CNT_W-1:0] rd_data_r;
  logic [ncc_pkg::SLOTS-1:0] vld_r;      // entry written since reset
  logic                      rd_vld_r;
  logic                      wr_en;
  logic [ncc_pkg::CNT_W-1:0] cnt_old, cnt_new;

  // last write, for a read issued on the same edge as that write
  logic                      lw_v_r;
  logic [ncc_pkg::IDX_W-1:0] lw_idx_r;
  logic [ncc_pkg::CNT_W-1:0] lw_data_r;

  assign wr_en = advance && s2_v_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[s2_idx_r] <= cnt_new;
    end
    if (advance) begin
      rd_data_r <= cnt_mem[best_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      lw_v_r   <= 1'b0;
    end else if (advance) begin
      rd_vld_r <= vld_r[best_idx];
      lw_v_r   <= s2_v_r;
      if (s2_v_r) begin
        vld_r[s2_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lw_idx_r  <= s2_idx_r;
      lw_data_r <= cnt_new;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: counter update and result register
  // --------------------------------------------------------------------------
  always_comb begin
    if (lw_v_r && (lw_idx_r == s2_idx_r)) begin
      cnt_old = lw_data_r;
    end else if (rd_vld_r) begin
      cnt_old = rd_data_r;
    end else begin
      cnt_old = '0;
    end
    cnt_new = ncc_pkg::sat_inc(cnt_old);
  end

  logic [ncc_pkg::CNT_W-1:0] total_r, total_nxt;

  assign total_nxt = ncc_pkg::sat_inc(total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (wr_en) begin
      total_r <= total_nxt;
    end
  end

  logic [ncc_pkg::IDX_W-1:0]  out_idx_r;
  logic [ncc_pkg::DIST_W-1:0] out_dist_r;
  logic [ncc_pkg::CNT_W-1:0]  out_cnt_r, out_seen_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_idx_r  <= s2_idx_r;
      out_dist_r <= ncc_pkg::fit_dist(s2_dist_r);
      out_cnt_r  <= cnt_new;
      out_seen_r <= total_nxt;
    end
  end

  assign out_valid               = out_v_r;
  assign out_nearest_index       = out_idx_r;
  assign out_nearest_sq_distance = out_dist_r;
  assign out_nearest_count       = out_cnt_r;
  assign out_points_seen         = out_seen_r;

endmodule

// ----- rtl/core/ncc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_checker: port-level checks for the classifier
// Backpressure, result stability and counter consistency.
// ----------------------------------------------------------------------------
module ncc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [ncc_pkg::IDX_W-1:0]   out_nearest_index,
  input logic [ncc_pkg::DIST_W-1:0]  out_nearest_sq_distance,
  input logic [ncc_pkg::CNT_W-1:0]   out_nearest_count,
  input logic [ncc_pkg::CNT_W-1:0]   out_points_seen
);

  // input only waits on a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_nearest_index)
      && $stable(out_nearest_sq_distance) && $stable(out_nearest_count)
      && $stable(out_points_seen)))
    else $error("stalled result changed");

  // consecutive results count up by one unless saturated
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) ##1 out_valid |->
      (out_points_seen == $past(out_points_seen) + ncc_pkg::CNT_W'(1))
      || (out_points_seen == ncc_pkg::CNT_MAX))
    else $error("points_seen did not step");

  a_count_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_nearest_count <= out_points_seen)
      && (out_nearest_count != '0))
    else $error("centroid count inconsistent with total");

endmodule

bind nearest_centroid_classifier ncc_checker u_ncc_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_stall                (in_stall),
  .out_valid               (out_valid),
  .out_stall               (out_stall),
  .out_nearest_index       (out_nearest_index),
  .out_nearest_sq_distance (out_nearest_sq_distance),
  .out_nearest_count       (out_nearest_count),
  .out_points_seen         (out_points_seen)
);

// ----- tb/sv/tb_nearest_centroid_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_centroid_classifier: self-checking bench for the classifier
// Streams 2D points through the block and checks every result against a
// local nearest-centroid predictor: index, squared distance, per-centroid
// count and running total. Centroids are reprogrammed over APB between
// phases and read back. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_nearest_centroid_classifier;
  import ncc_pkg::*;

  localparam int PIPE_SLACK = 6;                  // 3-stage pipe plus margin
  localparam int REG_STRIDE = 4;                  // byte step between registers
  localparam int COORD_MAX  = (1 << PORT_W) - 1;
  localparam int PHASES     = 7;
  localparam int PHASE_PTS  = 200;                // ~1400 random points overall

  // ---------------------------------------------------------------- types
  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] sq_dist;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  seen;
  } cls_result_t;

  typedef enum logic {ROW_LOAD, ROW_POINT} row_kind_t;

  // One directed row: either a full centroid set to load (one byte per
  // register index, index 0 in the low byte) or a point, optionally with
  // the index and distance typed in by hand.
  typedef struct {
    row_kind_t             kind;
    logic [PORT_W-1:0]     x;
    logic [PORT_W-1:0]     y;
    bit                    typed;
    logic [IDX_W-1:0]      idx;
    logic [DIST_W-1:0]     sq_dist;
    logic [8*2*SLOTS-1:0]  cents;
  } stim_row_t;

  typedef enum int {MODE_SCATTER, MODE_CORNERS, MODE_PAIRS, MODE_CLUSTER,
                    MODE_DEFAULT} cent_mode_t;

  // ---------------------------------------------------------------- signals
  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PORT_W-1:0]   in_point_x = '0;
  logic [PORT_W-1:0]   in_point_y = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [IDX_W-1:0]    out_nearest_index;
  logic [DIST_W-1:0]   out_nearest_sq_distance;
  logic [CNT_W-1:0]    out_nearest_count;
  logic [CNT_W-1:0]    out_points_seen;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  nearest_centroid_classifier u_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_point_x              (in_point_x),
    .in_point_y              (in_point_y),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_nearest_index       (out_nearest_index),
    .out_nearest_sq_distance (out_nearest_sq_distance),
    .out_nearest_count       (out_nearest_count),
    .out_points_seen         (out_points_seen),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  // Shadow of the centroid registers and of the assignment counters.
  logic [PORT_W-1:0] cent_coord [SLOTS][2];
  logic [PORT_W-1:0] next_cent  [SLOTS][2];     // staging for the next load
  logic [CNT_W-1:0]  hit_count  [SLOTS];
  logic [CNT_W-1:0]  point_total;

  cls_result_t       pending_results [$];       // in acceptance order
  stim_row_t         dir_rows [$];
  int                errors = 0;

  bit                stall_on = 1'b0;           // receiver backpressure enabled
  bit                gaps_on  = 1'b0;           // sender bubbles enabled
  int                stall_left = 0;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic void clear_model();
    for (int s = 0; s < SLOTS; s++) begin
      cent_coord[s][0] = RESET_COORD[s][0];
      cent_coord[s][1] = RESET_COORD[s][1];
      hit_count[s]     = '0;
    end
    point_total = '0;
  endfunction

  // Squared distance to each active centroid; strict less-than keeps the
  // lowest index on ties. Updates the counters like the block does.
  function automatic cls_result_t classify_point(input logic [PORT_W-1:0] px,
                                                 input logic [PORT_W-1:0] py);
    cls_result_t r;
    int unsigned mask, ax, ay, cx, cy, dx, dy, d, best;
    int          win;
    mask = (1 << COORD_BITS) - 1;
    ax   = px & mask;
    ay   = py & mask;
    best = 0;
    win  = 0;
    for (int j = 0; j < NUM_CENTROIDS; j++) begin
      cx = cent_coord[j][0] & mask;
      cy = cent_coord[j][1] & mask;
      dx = (ax >= cx) ? ax - cx : cx - ax;
      dy = (ay >= cy) ? ay - cy : cy - ay;
      d  = dx * dx + dy * dy;
      if (j == 0 || d < best) begin
        best = d;
        win  = j;
      end
    end
    hit_count[win] = bump(hit_count[win]);
    point_total    = bump(point_total);
    r.idx     = IDX_W'(win);
    r.sq_dist = DIST_W'(best);
    r.count   = hit_count[win];
    r.seen    = point_total;
    return r;
  endfunction

  // ---------------------------------------------------------------- helpers
  // Mostly back-to-back, sometimes a short bubble, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PORT_W-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return PORT_W'(COORD_MAX);
    return PORT_W'(v);
  endfunction

  function automatic logic [PORT_W-1:0] extreme_coord();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) return '0;
    if (r == 1) return PORT_W'(COORD_MAX);
    return PORT_W'($urandom);
  endfunction

  function automatic void add_row(input row_kind_t kind, input int x, input int y,
                                  input bit typed, input int idx, input int sq_dist,
                                  input logic [8*2*SLOTS-1:0] cents);
    stim_row_t row;
    row.kind    = kind;
    row.x       = PORT_W'(x);
    row.y       = PORT_W'(y);
    row.typed   = typed;
    row.idx     = IDX_W'(idx);
    row.sq_dist = DIST_W'(sq_dist);
    row.cents   = cents;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------- APB
  // One setup + access transaction. psel stays high so that accesses can run
  // back to back; apb_idle() drops the bus afterwards.
  task automatic apb_access(input bit wr, input int reg_idx,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(REG_STRIDE * reg_idx);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic apb_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read every centroid register back and compare with the shadow copy.
  task automatic check_centroid_regs();
    logic [DATA_W-1:0] rd;
    for (int s = 0; s < SLOTS; s++) begin
      for (int a = 0; a < 2; a++) begin
        apb_access(1'b0, 2 * s + a, '0, rd);
        if (rd !== DATA_W'(cent_coord[s][a])) begin
          errors++;
          $display("%0t ns: register %0d readback mismatch: expected %0d, actual %0d",
                   $time, 2 * s + a, cent_coord[s][a], rd);
        end
      end
    end
    apb_idle();
  endtask

  // Write next_cent into the block (x0, y0, x1, y1, ...) and the shadow.
  task automatic load_centroids();
    logic [DATA_W-1:0] unused_rd;
    for (int s = 0; s < SLOTS; s++) begin
      for (int a = 0; a < 2; a++) begin
        apb_access(1'b1, 2 * s + a, DATA_W'(next_cent[s][a]), unused_rd);
        cent_coord[s][a] = next_cent[s][a];
      end
    end
    check_centroid_regs();
  endtask

  // ---------------------------------------------------------------- point side
  // Present one point and hold it until the transaction completes; the
  // expectation is computed at acceptance so it sees the live counters.
  task automatic send_point(input logic [PORT_W-1:0] x, input logic [PORT_W-1:0] y,
                            input bit typed, input logic [IDX_W-1:0] idx,
                            input logic [DIST_W-1:0] sq_dist);
    cls_result_t r;
    in_valid   <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    do @(posedge clk); while (in_stall);
    r = classify_point(x, y);
    if (typed) begin
      r.idx     = idx;
      r.sq_dist = sq_dist;
    end
    pending_results.push_back(r);
  endtask

  task automatic rest_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Quiesce: sender stops and every outstanding result must come back
  // before the pipeline is considered idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiver
  // Backpressure: random stall bursts, independent of out_valid.
  always @(posedge clk) begin
    if (!stall_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 25) begin
      out_stall  <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall  <= 1'b0;
    end
  end

  task automatic check_field(input string what, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t ns: %s mismatch: expected %0d, actual %0d",
               $time, what, want_v, got_v);
    end
  endtask

  // Result checker: each completed output transaction against the oldest
  // expectation.
  cls_result_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result: expected none, actual index %0d dist %0d",
                 $time, out_nearest_index, out_nearest_sq_distance);
      end else begin
        want = pending_results.pop_front();
        check_field("nearest_index", 64'(want.idx), 64'(out_nearest_index));
        check_field("nearest_sq_distance", 64'(want.sq_dist),
                    64'(out_nearest_sq_distance));
        check_field("nearest_count", 64'(want.count), 64'(out_nearest_count));
        check_field("points_seen", 64'(want.seen), 64'(out_points_seen));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin
    cent_mode_t        mode;
    logic [PORT_W-1:0] px, py, base_x, base_y;
    int                r, s, s2;

    clear_model();

    // Directed rows. Default centroids first: exact hits on each centroid,
    // a four-way tie at the center, a two-way tie, far corners.
    add_row(ROW_POINT,  75,  25, 1, 0, 0, '0);
    add_row(ROW_POINT,  25,  25, 1, 1, 0, '0);
    add_row(ROW_POINT,  25,  75, 1, 2, 0, '0);
    add_row(ROW_POINT,  75,  75, 1, 3, 0, '0);
    add_row(ROW_POINT,  50,  50, 1, 0, 1250, '0);
    add_row(ROW_POINT,  50,  75, 1, 2, 625, '0);
    add_row(ROW_POINT,   0,   0, 1, 1, 1250, '0);
    add_row(ROW_POINT, 255, 255, 1, 3, 64800, '0);
    add_row(ROW_POINT, 255,   0, 1, 0, 33025, '0);
    add_row(ROW_POINT,   0, 255, 1, 2, 33025, '0);
    // All centroids at the origin: every point ties, largest distance.
    add_row(ROW_LOAD,    0,   0, 0, 0, 0, '0);
    add_row(ROW_POINT, 255, 255, 1, 0, 130050, '0);
    add_row(ROW_POINT,   0,   0, 1, 0, 0, '0);
    add_row(ROW_POINT, 170,  85, 0, 0, 0, '0);
    // All centroids at the far corner.
    add_row(ROW_LOAD,    0,   0, 0, 0, 0, '1);
    add_row(ROW_POINT,   0,   0, 1, 0, 130050, '0);
    add_row(ROW_POINT, 255, 255, 1, 0, 0, '0);
    // One centroid per corner of the plane.
    add_row(ROW_LOAD,    0,   0, 0, 0, 0, 64'hFFFF_FF00_00FF_0000);
    add_row(ROW_POINT, 255,   0, 1, 1, 0, '0);
    add_row(ROW_POINT,   0, 255, 1, 2, 0, '0);
    add_row(ROW_POINT, 255, 255, 1, 3, 0, '0);
    add_row(ROW_POINT, 128, 128, 1, 3, 32258, '0);
    add_row(ROW_POINT, 127, 127, 1, 0, 32258, '0);
    add_row(ROW_POINT, 127, 128, 0, 0, 0, '0);
    // All four centroids stacked on one spot (100, 200).
    add_row(ROW_LOAD,    0,   0, 0, 0, 0, 64'hC864_C864_C864_C864);
    add_row(ROW_POINT, 100, 200, 1, 0, 0, '0);
    add_row(ROW_POINT,  90, 210, 1, 0, 200, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_centroid_regs();      // reset values

    stall_on = 1'b1;
    gaps_on  = 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LOAD) begin
        drain_results();
        for (int k = 0; k < SLOTS; k++) begin
          next_cent[k][0] = dir_rows[i].cents[8 * (2 * k)     +: 8];
          next_cent[k][1] = dir_rows[i].cents[8 * (2 * k + 1) +: 8];
        end
        load_centroids();
      end else begin
        send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed,
                   dir_rows[i].idx, dir_rows[i].sq_dist);
        rest_sender(gaps_on ? pick_gap() : 0);
      end
    end

    // Random phases: a new centroid layout per phase, loaded while idle.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      mode = cent_mode_t'(ph % 5);
      base_x = PORT_W'($urandom);
      base_y = PORT_W'($urandom);
      for (int k = 0; k < SLOTS; k++) begin
        case (mode)
          MODE_SCATTER: begin
            next_cent[k][0] = PORT_W'($urandom);
            next_cent[k][1] = PORT_W'($urandom);
          end
          MODE_CORNERS: begin
            next_cent[k][0] = $urandom_range(0, 1) ? PORT_W'(COORD_MAX) : '0;
            next_cent[k][1] = $urandom_range(0, 1) ? PORT_W'(COORD_MAX) : '0;
          end
          MODE_PAIRS: begin
            // odd slots copy the even slot below them: exact ties everywhere
            if (k % 2 == 0) begin
              next_cent[k][0] = PORT_W'($urandom);
              next_cent[k][1] = PORT_W'($urandom);
            end else begin
              next_cent[k][0] = next_cent[k - 1][0];
              next_cent[k][1] = next_cent[k - 1][1];
            end
          end
          MODE_CLUSTER: begin
            next_cent[k][0] = clamp_coord(int'(base_x) + int'($urandom_range(0, 6)) - 3);
            next_cent[k][1] = clamp_coord(int'(base_y) + int'($urandom_range(0, 6)) - 3);
          end
          default: begin
            next_cent[k][0] = RESET_COORD[k][0];
            next_cent[k][1] = RESET_COORD[k][1];
          end
        endcase
      end
      load_centroids();

      // idle pattern cycles through none / sender only / receiver only / both
      gaps_on  = (ph % 4 == 1) || (ph % 4 == 3);
      stall_on = (ph % 4 == 2) || (ph % 4 == 3);

      for (int n = 0; n < PHASE_PTS; n++) begin
        r  = $urandom_range(0, 99);
        s  = $urandom_range(0, SLOTS - 1);
        s2 = $urandom_range(0, SLOTS - 1);
        if (r < 40) begin
          px = PORT_W'($urandom);
          py = PORT_W'($urandom);
        end else if (r < 65) begin
          // close to one centroid
          px = clamp_coord(int'(cent_coord[s][0]) + int'($urandom_range(0, 16)) - 8);
          py = clamp_coord(int'(cent_coord[s][1]) + int'($urandom_range(0, 16)) - 8);
        end else if (r < 80) begin
          // halfway between two centroids: ties when the sums are even
          px = PORT_W'((int'(cent_coord[s][0]) + int'(cent_coord[s2][0])) / 2);
          py = PORT_W'((int'(cent_coord[s][1]) + int'(cent_coord[s2][1])) / 2);
        end else if (r < 90) begin
          px = cent_coord[s][0];
          py = cent_coord[s][1];
        end else begin
          px = extreme_coord();
          py = extreme_coord();
        end
        send_point(px, py, 1'b0, '0, '0);
        rest_sender(gaps_on ? pick_gap() : 0);
      end
    end

    // Everything sent; wait for the tail and a few quiet cycles.
    drain_results();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every point and result
  // hitting the longest bubble and stall).
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- nearest_centroid_classifier.f -----
rtl/core/ncc_pkg.sv
rtl/core/nearest_centroid_classifier.sv
rtl/core/ncc_checker.sv
tb/sv/tb_nearest_centroid_classifier.sv
